[rtl/fmhb_pkg.sv]
// Package for the four-motor H-bridge drive: command codes, duty constants
// and the motor-to-channel pin map. No dependencies.
package fmhb_pkg;

  localparam int unsigned MOTOR_COUNT  = 4;
  localparam int unsigned NUM_CHANNELS = 8;
  localparam int unsigned DUTY_W       = 12;
  localparam int unsigned SPEED_W      = 16;
  localparam int unsigned MS_W         = 16;
  localparam int unsigned ELAPSED_W    = 17;
  localparam int unsigned MOTOR_W      = 2;
  localparam int unsigned CHAN_W       = 3;

  localparam logic [DUTY_W-1:0]    DUTY_FULL   = 12'd4095;
  localparam logic [DUTY_W-1:0]    DUTY_OFF    = 12'd0;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 17'd131071;
  localparam logic signed [SPEED_W-1:0] SPEED_MAX = 16'sd255;
  localparam logic signed [SPEED_W-1:0] SPEED_MIN = -16'sd255;

  typedef enum logic [2:0] {
    FN_SET_CHANGED = 3'd0,
    FN_SET_ALWAYS  = 3'd1,
    FN_BRAKE_ONE   = 3'd2,
    FN_COAST_ONE   = 3'd3,
    FN_BRAKE_ALL   = 3'd4,
    FN_COAST_ALL   = 3'd5,
    FN_TIMED_BRAKE = 3'd6,
    FN_TICK        = 3'd7
  } func_t;

  typedef logic [DUTY_W-1:0]  duty_t;
  typedef logic [SPEED_W-1:0] speed_t;
  typedef logic [CHAN_W-1:0]  chan_t;

  // IN1 and IN2 channel of each motor; the right side is wired mirrored.
  localparam chan_t PIN_A [MOTOR_COUNT] = '{3'd0, 3'd2, 3'd7, 3'd5};
  localparam chan_t PIN_B [MOTOR_COUNT] = '{3'd1, 3'd3, 3'd6, 3'd4};

endpackage

[rtl/four_motor_hbridge_drive.sv]
// Four-motor H-bridge drive: command decode, duty bank, stored speeds and
// timed brake in one registered stage. Depends on fmhb_pkg.

// Takes one command per clock cycle and returns one result beat per
// command, in the cycle after acceptance. The command is decoded and applied to
// the duty bank, the four stored speeds and the timed-brake counter in a
// single pass of logic; the result sits in an output register, and a new
// command is taken in the same cycle that the waiting result is taken, so
// the rate is one command per cycle as long as the consumer keeps out_ready
// high. The duty and braking outputs show the bank as it stands after the
// command of the beat they belong to.
module four_motor_hbridge_drive
  import fmhb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_func,
  input  logic [MOTOR_W-1:0] in_motor,
  input  logic signed [15:0] in_speed,
  input  logic [MS_W-1:0]    in_brake_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_flush,
  output logic [11:0]        out_duty_0,
  output logic [11:0]        out_duty_1,
  output logic [11:0]        out_duty_2,
  output logic [11:0]        out_duty_3,
  output logic [11:0]        out_duty_4,
  output logic [11:0]        out_duty_5,
  output logic [11:0]        out_duty_6,
  output logic [11:0]        out_duty_7,
  output logic               out_braking_now,
  output logic signed [15:0] out_motor_speed
);

  speed_t               speed_r      [MOTOR_COUNT];
  speed_t               speed_nxt    [MOTOR_COUNT];
  duty_t                duty_r       [NUM_CHANNELS];
  duty_t                duty_nxt     [NUM_CHANNELS];
  logic                 brake_r,     brake_nxt;
  logic [ELAPSED_W-1:0] elapsed_r,   elapsed_nxt;
  logic [MS_W-1:0]      length_r,    length_nxt;
  logic                 out_valid_r;
  logic                 flush_r,     flush_nxt;
  speed_t               mspeed_r;

  logic                 accept;
  func_t                func;
  logic [7:0]           mag;
  duty_t                drive_duty;
  logic                 drive_en;
  logic                 hold_one_en;
  logic                 hold_all_en;
  duty_t                hold_level;
  logic [ELAPSED_W-1:0] elapsed_inc;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign func     = func_t'(in_func);

  // Clamp to +/-255 and scale by 16; the sign picks IN1 or IN2.
  always_comb begin
    if (in_speed[15]) begin
      mag = (in_speed < SPEED_MIN) ? 8'd255 : 8'((-in_speed));
    end else begin
      mag = (in_speed > SPEED_MAX) ? 8'd255 : in_speed[7:0];
    end
    drive_duty = {mag, 4'b0000};
  end

  assign elapsed_inc = (elapsed_r == ELAPSED_MAX) ? elapsed_r : elapsed_r + 1'b1;

  always_comb begin
    drive_en    = 1'b0;
    hold_one_en = 1'b0;
    hold_all_en = 1'b0;
    hold_level  = DUTY_OFF;
    flush_nxt   = 1'b0;
    brake_nxt   = brake_r;
    elapsed_nxt = elapsed_r;
    length_nxt  = length_r;
    unique case (func)
      FN_SET_CHANGED: begin
        drive_en  = (speed_r[in_motor] != speed_t'(in_speed));
        flush_nxt = drive_en;
      end
      FN_SET_ALWAYS: begin
        drive_en  = 1'b1;
        flush_nxt = 1'b1;
      end
      FN_BRAKE_ONE: begin
        hold_one_en = 1'b1;
        hold_level  = DUTY_FULL;
        flush_nxt   = 1'b1;
      end
      FN_COAST_ONE: begin
        hold_one_en = 1'b1;
        flush_nxt   = 1'b1;
      end
      FN_BRAKE_ALL: begin
        hold_all_en = 1'b1;
        hold_level  = DUTY_FULL;
        flush_nxt   = 1'b1;
      end
      FN_COAST_ALL: begin
        hold_all_en = 1'b1;
        flush_nxt   = 1'b1;
      end
      FN_TIMED_BRAKE: begin
        hold_all_en = 1'b1;
        hold_level  = DUTY_FULL;
        flush_nxt   = 1'b1;
        brake_nxt   = 1'b1;
        elapsed_nxt = '0;
        length_nxt  = in_brake_ms;
      end
      FN_TICK: begin
        if (brake_r) begin
          elapsed_nxt = elapsed_inc;
          if (elapsed_inc >= {1'b0, length_r}) begin
            hold_all_en = 1'b1;
            brake_nxt   = 1'b0;
            flush_nxt   = 1'b1;
          end
        end
      end
    endcase
  end

  // Per-motor update of the duty pair and the stored speed.
  always_comb begin
    duty_nxt  = duty_r;
    speed_nxt = speed_r;
    for (int m = 0; m < MOTOR_COUNT; m++) begin
      if (hold_all_en || (hold_one_en && in_motor == MOTOR_W'(m))) begin
        duty_nxt[PIN_A[m]] = hold_level;
        duty_nxt[PIN_B[m]] = hold_level;
        speed_nxt[m]       = '0;
      end else if (drive_en && in_motor == MOTOR_W'(m)) begin
        duty_nxt[PIN_A[m]] = in_speed[15] ? DUTY_OFF : drive_duty;
        duty_nxt[PIN_B[m]] = in_speed[15] ? drive_duty : DUTY_OFF;
        speed_nxt[m]       = speed_t'(in_speed);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      flush_r     <= 1'b0;
      brake_r     <= 1'b0;
      elapsed_r   <= '0;
      length_r    <= '0;
      mspeed_r    <= '0;
      for (int m = 0; m < MOTOR_COUNT; m++) speed_r[m] <= '0;
      for (int c = 0; c < NUM_CHANNELS; c++) duty_r[c] <= DUTY_OFF;
    end else begin
      if (accept) begin
        out_valid_r <= 1'b1;
        flush_r     <= flush_nxt;
        brake_r     <= brake_nxt;
        elapsed_r   <= elapsed_nxt;
        length_r    <= length_nxt;
        mspeed_r    <= speed_nxt[in_motor];
        speed_r     <= speed_nxt;
        duty_r      <= duty_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The bank only changes on an accepted beat, which also replaces the
  // result, so the live bank always belongs to the beat on the outputs.
  assign out_valid       = out_valid_r;
  assign out_flush       = flush_r;
  assign out_duty_0      = duty_r[0];
  assign out_duty_1      = duty_r[1];
  assign out_duty_2      = duty_r[2];
  assign out_duty_3      = duty_r[3];
  assign out_duty_4      = duty_r[4];
  assign out_duty_5      = duty_r[5];
  assign out_duty_6      = duty_r[6];
  assign out_duty_7      = duty_r[7];
  assign out_braking_now = brake_r;
  assign out_motor_speed = mspeed_r;

`ifndef NO_ASSERTIONS
  a_timed_brake: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_func == FN_TIMED_BRAKE |=>
      out_valid && out_flush && out_braking_now && out_duty_0 == DUTY_FULL &&
      out_duty_7 == DUTY_FULL && out_motor_speed == 16'sd0)
    else $error("timed brake did not brake all motors");

  a_coast_all: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_func == FN_COAST_ALL |=>
      out_flush && out_duty_1 == DUTY_OFF && out_duty_4 == DUTY_OFF &&
      out_motor_speed == 16'sd0)
    else $error("coast all left a channel driven");

  a_same_speed: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_func == FN_SET_CHANGED && speed_r[in_motor] == speed_t'(in_speed) |=>
      !out_flush && $stable(duty_r[0]) && $stable(duty_r[5]))
    else $error("unchanged speed caused a flush");

  a_brake_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(brake_r) && out_valid |-> out_flush && out_duty_2 == DUTY_OFF)
    else $error("brake ended without coasting");
`endif

endmodule
